[hdl/smht_pkg.sv]
// Shared types, constants and helpers for the sprite mask hit test block.
package smht_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int MASK_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int MADDR_W     = $clog2(MASK_DEPTH);
	localparam int X_W         = $clog2(MAX_WIDTH);
	localparam int Y_W         = $clog2(MAX_HEIGHT);
	localparam int DIM_W       = 9;
	localparam int TOTAL_W     = 17;
	localparam int COORD_W     = 17;
	localparam int CELL_IDX_W  = 16;
	localparam int CEIL_W      = 14;
	localparam int OFFX_W      = 2 * DIM_W;
	localparam int OFFY_W      = CELL_IDX_W + DIM_W;
	localparam int POS_W       = OFFY_W + 2;
	localparam int REG_IDX_W   = 3;

	localparam logic [7:0] OPACITY_LIMIT = 8'h7F;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_IMAGE_WIDTH  = 3'd0;
	localparam reg_idx_t REG_IMAGE_HEIGHT = 3'd1;
	localparam reg_idx_t REG_CELL_WIDTH   = 3'd2;
	localparam reg_idx_t REG_CELL_HEIGHT  = 3'd3;
	localparam reg_idx_t REG_CELL_COLUMNS = 3'd4;
	localparam reg_idx_t REG_CELL_TOTAL   = 3'd5;

	typedef struct packed {
		logic [DIM_W-1:0]   image_width;
		logic [DIM_W-1:0]   image_height;
		logic [DIM_W-1:0]   cell_width;
		logic [DIM_W-1:0]   cell_height;
		logic [DIM_W-1:0]   cell_columns;
		logic [TOTAL_W-1:0] cell_total;
	} cfg_t;

	typedef struct packed {
		logic                     is_query;
		logic                     opaque;
		logic                     cell_ok;
		logic [CELL_IDX_W-1:0]    cell_idx;
		logic signed [CEIL_W-1:0] cx;
		logic signed [CEIL_W-1:0] cy;
	} entry_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > hi) begin
			r = DIM_W'(hi);
		end
		return r;
	endfunction

endpackage

[hdl/smht_fifo.sv]
// Two-entry queue between the front classifier and the back engine.
module smht_fifo
	import smht_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	entry_t     slots_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/smht_front.sv]
// Front end: accepts items, classifies loads and queries, queues them.
module smht_front
	import smht_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      opcode,
	input  logic [31:0]               pixel_word,
	input  logic signed [COORD_W-1:0] query_cell,
	input  logic signed [COORD_W-1:0] query_x,
	input  logic signed [COORD_W-1:0] query_y,
	input  cfg_t                      cfg,
	input  logic                      pop,
	output entry_t                    head,
	output logic                      empty
);

	entry_t                    ent;
	logic                      full;
	logic signed [COORD_W:0]   x_sum;
	logic signed [COORD_W:0]   y_sum;

	always_comb begin
		x_sum        = {query_x[COORD_W-1], query_x} + (COORD_W+1)'(15);
		y_sum        = {query_y[COORD_W-1], query_y} + (COORD_W+1)'(15);
		ent.is_query = opcode;
		ent.opaque   = (pixel_word[7:0] > OPACITY_LIMIT);
		ent.cell_idx = query_cell[CELL_IDX_W-1:0];
		ent.cell_ok  = !query_cell[COORD_W-1]
			&& ({1'b0, query_cell[CELL_IDX_W-1:0]} < cfg.cell_total)
			&& (cfg.cell_columns != '0);
		ent.cx       = x_sum[COORD_W:4];
		ent.cy       = y_sum[COORD_W:4];
	end

	assign busy = full;

	smht_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (start && !full),
		.push_data (ent),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

endmodule

[hdl/smht_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module smht_div
	import smht_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [CELL_IDX_W-1:0] dividend,
	input  logic [DIM_W-1:0]      divisor,
	output logic                  done,
	output logic [CELL_IDX_W-1:0] quot,
	output logic [DIM_W-1:0]      rem
);

	localparam int CNT_W = $clog2(CELL_IDX_W + 1);

	logic [CELL_IDX_W-1:0] quot_q;
	logic [DIM_W-1:0]      rem_q;
	logic [DIM_W-1:0]      dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [DIM_W:0]        trial;
	logic [DIM_W:0]        diff;
	logic                  ge;

	always_comb begin
		trial = {rem_q, quot_q[CELL_IDX_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (run_q) begin
			quot_q <= {quot_q[CELL_IDX_W-2:0], ge};
			rem_q  <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(CELL_IDX_W - 1);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

endmodule

[hdl/smht_back.sv]
// Back end: mask store, load pointer and the query address engine.
module smht_back
	import smht_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   dim_clear,
	input  logic   empty,
	input  entry_t head,
	output logic   pop,
	output logic   result_valid,
	output logic   hit
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_ADD,
		S_CHK,
		S_READ,
		S_RESP
	} state_t;

	localparam int ASUM_W = MADDR_W + 1;

	state_t                    state_q;
	entry_t                    ent_q;
	logic                      mask_mem [MASK_DEPTH];
	logic                      rd_q;
	logic [MADDR_W-1:0]        ptr_q;
	logic                      ready_q;
	logic [OFFX_W-1:0]         offx_q;
	logic [OFFY_W-1:0]         offy_q;
	logic signed [POS_W-1:0]   px_q;
	logic signed [POS_W-1:0]   py_q;
	logic                      inb_q;
	logic [MADDR_W-1:0]        addr_q;
	logic                      result_valid_q;
	logic                      hit_q;

	logic [DIM_W-1:0]          w;
	logic [DIM_W-1:0]          h;
	logic [ASUM_W-1:0]         size;
	logic [ASUM_W-1:0]         ptr_next;
	logic [ASUM_W-1:0]         addr_sum;
	logic                      mem_we;
	logic                      div_start;
	logic                      div_done;
	logic [CELL_IDX_W-1:0]     quot;
	logic [DIM_W-1:0]          rem;
	logic                      in_x;
	logic                      in_y;

	always_comb begin
		w         = clamp_dim(cfg.image_width, MAX_WIDTH);
		h         = clamp_dim(cfg.image_height, MAX_HEIGHT);
		size      = ASUM_W'(w) * ASUM_W'(h);
		ptr_next  = {1'b0, ptr_q} + ASUM_W'(1);
		pop       = (state_q == S_IDLE) && !empty;
		mem_we    = pop && !head.is_query;
		div_start = pop && head.is_query && head.cell_ok;
		addr_sum  = ASUM_W'(py_q[Y_W-1:0]) * ASUM_W'(w) + ASUM_W'(px_q[X_W-1:0]);
		in_x      = !px_q[POS_W-1] && (px_q < POS_W'(w));
		in_y      = !py_q[POS_W-1] && (py_q < POS_W'(h));
	end

	assign result_valid = result_valid_q;
	assign hit          = hit_q;

	smht_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (head.cell_idx),
		.divisor  (cfg.cell_columns),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mask_mem[ptr_q] <= head.opaque;
		end
		rd_q <= mask_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
		end
		if (state_q == S_MUL) begin
			offx_q <= ent_q.cell_ok ? OFFX_W'(rem) * OFFX_W'(cfg.cell_width) : '0;
			offy_q <= ent_q.cell_ok ? OFFY_W'(quot) * OFFY_W'(cfg.cell_height) : '0;
		end
		if (state_q == S_ADD) begin
			px_q <= POS_W'(ent_q.cx) + POS_W'(signed'({1'b0, offx_q}));
			py_q <= POS_W'(ent_q.cy) + POS_W'(signed'({1'b0, offy_q}));
		end
		if (state_q == S_CHK) begin
			inb_q  <= ready_q && in_x && in_y;
			addr_q <= addr_sum[MADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ptr_q          <= '0;
			ready_q        <= 1'b0;
			result_valid_q <= 1'b0;
			hit_q          <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (dim_clear) begin
				ptr_q   <= '0;
				ready_q <= 1'b0;
			end else if (mem_we) begin
				if (ptr_next >= size) begin
					ptr_q   <= '0;
					ready_q <= 1'b1;
				end else begin
					ptr_q <= ptr_next[MADDR_W-1:0];
				end
			end
			case (state_q)
				S_IDLE: begin
					if (pop && head.is_query) begin
						state_q <= head.cell_ok ? S_DIV : S_MUL;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:  state_q <= S_ADD;
				S_ADD:  state_q <= S_CHK;
				S_CHK:  state_q <= S_READ;
				S_READ: state_q <= S_RESP;
				S_RESP: begin
					result_valid_q <= 1'b1;
					hit_q          <= inb_q & rd_q;
					state_q        <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hdl/sprite_mask_hit_test.sv]
// Top level of the sprite mask hit test block: configuration and wiring.
//
// Items enter on start while busy is low and wait in a two-entry queue; busy is
// high only while that queue is full. A load (opcode 0) writes one mask bit as it
// leaves the queue, giving no result. A query (opcode 1) gives one result, a
// one-cycle pulse on result_valid with hit, after the 16-step divider that splits
// the cell index by the column count when the cell is valid, then multiply, add,
// bounds check and the registered mask read; an invalid cell skips the divider.
// Results leave in input order and cannot be held off by the receiver. The mask
// store is not cleared after reset; cfg_ready is always high, and writing
// image_width or image_height restarts loading from the first pixel.
module sprite_mask_hit_test
	import smht_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      opcode,
	input  logic [31:0]               pixel_word,
	input  logic signed [COORD_W-1:0] query_cell,
	input  logic signed [COORD_W-1:0] query_x,
	input  logic signed [COORD_W-1:0] query_y,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [REG_IDX_W-1:0]      cfg_index,
	input  logic [TOTAL_W-1:0]        cfg_data,
	output logic                      result_valid,
	output logic                      hit
);

	cfg_t   cfg_q;
	logic   cfg_wr;
	logic   dim_clear;
	logic   pop;
	logic   empty;
	entry_t head;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign dim_clear = cfg_wr
		&& ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= DIM_W'(256);
			cfg_q.image_height <= DIM_W'(256);
			cfg_q.cell_width   <= DIM_W'(256);
			cfg_q.cell_height  <= DIM_W'(256);
			cfg_q.cell_columns <= DIM_W'(1);
			cfg_q.cell_total   <= TOTAL_W'(1);
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[DIM_W-1:0];
				REG_CELL_WIDTH:   cfg_q.cell_width   <= cfg_data[DIM_W-1:0];
				REG_CELL_HEIGHT:  cfg_q.cell_height  <= cfg_data[DIM_W-1:0];
				REG_CELL_COLUMNS: cfg_q.cell_columns <= cfg_data[DIM_W-1:0];
				REG_CELL_TOTAL:   cfg_q.cell_total   <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	smht_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.pixel_word (pixel_word),
		.query_cell (query_cell),
		.query_x    (query_x),
		.query_y    (query_y),
		.cfg        (cfg_q),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	smht_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.dim_clear    (dim_clear),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.hit          (hit)
	);

endmodule

[tb/tb_top.sv]
// Self-checking testbench for sprite_mask_hit_test: directed table, then random sheets.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import smht_pkg::*;

	typedef enum logic {OP_LOAD = 1'b0, OP_QUERY = 1'b1} op_e;

	typedef struct packed {
		op_e                op;
		logic [31:0]        word;
		logic [COORD_W-1:0] cell_id;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               fixed;
		logic               want;
	} row_t;

	localparam int ITEM_TARGET   = 1700;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int RESHAPE_ROW   = 3;
	localparam int PRINT_CAP     = 40;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic                      opcode = 1'b0;
	logic [31:0]               pixel_word = '0;
	logic signed [COORD_W-1:0] query_cell = '0;
	logic signed [COORD_W-1:0] query_x = '0;
	logic signed [COORD_W-1:0] query_y = '0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [REG_IDX_W-1:0]      cfg_index = '0;
	logic [TOTAL_W-1:0]        cfg_data = '0;
	logic                      result_valid;
	logic                      hit;

	// predictor copy of the registers and the mask
	logic [DIM_W-1:0]   sheet_w_reg = 9'd256;
	logic [DIM_W-1:0]   sheet_h_reg = 9'd256;
	logic [DIM_W-1:0]   cell_w_reg = 9'd256;
	logic [DIM_W-1:0]   cell_h_reg = 9'd256;
	logic [DIM_W-1:0]   cell_cols_reg = 9'd1;
	logic [TOTAL_W-1:0] cell_total_reg = 17'd1;
	bit                 mask_bits [MASK_DEPTH];
	int                 load_ptr = 0;
	bit                 mask_ready = 1'b0;

	bit     hits_pending [$];
	int     beats_in = 0;
	int     loads_in = 0;
	int     queries_in = 0;
	int     hits_checked = 0;
	int     mismatches = 0;
	int     sheets = 0;
	longint cycles = 0;

	row_t plan [22] = '{
		'{OP_QUERY, 32'h00000000, 17'h00000, 17'h00000, 17'h00000, 1'b1, 1'b0},
		'{OP_QUERY, 32'hFFFFFFFF, 17'h1FFFF, 17'h10000, 17'h0FFFF, 1'b1, 1'b0},
		'{OP_QUERY, 32'h00000000, 17'h0FFFF, 17'h0FFFF, 17'h10000, 1'b1, 1'b0},
		'{OP_LOAD,  32'h00000000, 17'h00000, 17'h00000, 17'h00000, 1'b0, 1'b0},
		'{OP_LOAD,  32'h0000007F, 17'h00000, 17'h00000, 17'h00000, 1'b0, 1'b0},
		'{OP_LOAD,  32'h00000080, 17'h00000, 17'h00000, 17'h00000, 1'b0, 1'b0},
		'{OP_LOAD,  32'hFFFFFFFF, 17'h00000, 17'h00000, 17'h00000, 1'b0, 1'b0},
		'{OP_LOAD,  32'hFFFFFF7F, 17'h00000, 17'h00000, 17'h00000, 1'b0, 1'b0},
		'{OP_LOAD,  32'h12345680, 17'h00000, 17'h00000, 17'h00000, 1'b0, 1'b0},
		'{OP_LOAD,  32'h000000FE, 17'h00000, 17'h00000, 17'h00000, 1'b0, 1'b0},
		'{OP_LOAD,  32'hABCDEF01, 17'h00000, 17'h00000, 17'h00000, 1'b0, 1'b0},
		'{OP_QUERY, 32'h00000000, 17'h00000, 17'h00020, 17'h00000, 1'b0, 1'b0},
		'{OP_QUERY, 32'h00000000, 17'h00001, 17'h00000, 17'h00000, 1'b0, 1'b0},
		'{OP_QUERY, 32'h00000000, 17'h00003, 17'h00010, 17'h00000, 1'b0, 1'b0},
		'{OP_QUERY, 32'h00000000, 17'h00002, 17'h00001, 17'h00000, 1'b0, 1'b0},
		'{OP_QUERY, 32'h00000000, 17'h00000, 17'h0002F, 17'h00001, 1'b0, 1'b0},
		'{OP_QUERY, 32'h00000000, 17'h00000, 17'h1FFF0, 17'h00000, 1'b1, 1'b0},
		'{OP_QUERY, 32'h00000000, 17'h00000, 17'h00040, 17'h00000, 1'b1, 1'b0},
		'{OP_QUERY, 32'h00000000, 17'h00004, 17'h00020, 17'h00010, 1'b0, 1'b0},
		'{OP_QUERY, 32'h00000000, 17'h1FFFF, 17'h00030, 17'h1FFF1, 1'b0, 1'b0},
		'{OP_QUERY, 32'h00000000, 17'h00003, 17'h00000, 17'h00010, 1'b1, 1'b0},
		'{OP_QUERY, 32'h00000000, 17'h00000, 17'h1FFFF, 17'h1FFFF, 1'b0, 1'b0}
	};

	sprite_mask_hit_test dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.pixel_word   (pixel_word),
		.query_cell   (query_cell),
		.query_x      (query_x),
		.query_y      (query_y),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.hit          (hit)
	);

	always #4 clk = ~clk;

	function automatic int used_dim(input logic [DIM_W-1:0] v, input int top);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > top) begin
			return top;
		end
		return int'(v);
	endfunction

	function automatic int ceil_pixel(input logic signed [COORD_W-1:0] v);
		int s;
		s = int'(v);
		if (s >= 0) begin
			return (s + 15) / 16;
		end
		return -((-s) / 16);
	endfunction

	function automatic void load_mask_bit(input logic [31:0] word);
		int size;
		size = used_dim(sheet_w_reg, MAX_WIDTH) * used_dim(sheet_h_reg, MAX_HEIGHT);
		if (load_ptr < size) begin
			mask_bits[load_ptr] = word[7:0] > OPACITY_LIMIT;
		end
		if (load_ptr + 1 >= size) begin
			load_ptr = 0;
			mask_ready = 1'b1;
		end else begin
			load_ptr++;
		end
	endfunction

	function automatic bit mask_hit_of(input logic signed [COORD_W-1:0] cell_id, x, y);
		int     w;
		int     h;
		int     c;
		longint px;
		longint py;
		w = used_dim(sheet_w_reg, MAX_WIDTH);
		h = used_dim(sheet_h_reg, MAX_HEIGHT);
		c = int'(cell_id);
		px = longint'(ceil_pixel(x));
		py = longint'(ceil_pixel(y));
		if (c >= 0 && c < int'(cell_total_reg) && cell_cols_reg != '0) begin
			px += longint'((c % int'(cell_cols_reg)) * int'(cell_w_reg));
			py += longint'((c / int'(cell_cols_reg)) * int'(cell_h_reg));
		end
		if (!mask_ready || px < 0 || px >= w || py < 0 || py >= h) begin
			return 1'b0;
		end
		return mask_bits[int'(px + py * w)];
	endfunction

	// fixed-point coordinate whose ceiling lands just around [0, span)
	function automatic logic signed [COORD_W-1:0] pick_coord(input int span);
		int t;
		if ($urandom_range(9) < 2) begin
			return COORD_W'($urandom);
		end
		t = int'($urandom_range(span + 2)) - 1;
		return COORD_W'(t * 16 - int'($urandom_range(15)));
	endfunction

	task automatic report(input string what);
		if (mismatches < PRINT_CAP) begin
			$display("%0t mismatch: %s", $time, what);
		end
		mismatches++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input int data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= TOTAL_W'(data);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_IMAGE_WIDTH: begin
				sheet_w_reg = DIM_W'(data);
				load_ptr = 0;
				mask_ready = 1'b0;
			end
			REG_IMAGE_HEIGHT: begin
				sheet_h_reg = DIM_W'(data);
				load_ptr = 0;
				mask_ready = 1'b0;
			end
			REG_CELL_WIDTH: cell_w_reg = DIM_W'(data);
			REG_CELL_HEIGHT: cell_h_reg = DIM_W'(data);
			REG_CELL_COLUMNS: cell_cols_reg = DIM_W'(data);
			REG_CELL_TOTAL: cell_total_reg = TOTAL_W'(data);
			default: ;
		endcase
	endtask

	task automatic set_sheet(input bit reshape, input int w, h, cw, ch, cols, total);
		if (reshape) begin
			write_reg(REG_IMAGE_WIDTH, w);
			write_reg(REG_IMAGE_HEIGHT, h);
		end
		write_reg(REG_CELL_WIDTH, cw);
		write_reg(REG_CELL_HEIGHT, ch);
		write_reg(REG_CELL_COLUMNS, cols);
		write_reg(REG_CELL_TOTAL, total);
		cfg_valid <= 1'b0;
		sheets++;
	endtask

	// all hits back, then time for a trailing load to retire
	task automatic settle();
		start <= 1'b0;
		while (hits_pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(input op_e op, input logic [31:0] word,
			input logic signed [COORD_W-1:0] cell_id, x, y, input bit fixed, want);
		int pct;
		pct = beats_in < ITEM_TARGET / 3 ? 34 : (beats_in < 2 * ITEM_TARGET / 3 ? 81 : 0);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < pct);
		end
		start <= 1'b1;
		opcode <= op;
		pixel_word <= word;
		query_cell <= cell_id;
		query_x <= x;
		query_y <= y;
		do @(posedge clk); while (busy);
		beats_in++;
		if (op == OP_LOAD) begin
			load_mask_bit(word);
			loads_in++;
		end else begin
			hits_pending.push_back(fixed ? want : mask_hit_of(cell_id, x, y));
			queries_in++;
		end
	endtask

	task automatic random_query();
		int c;
		int total;
		int sel;
		int xs;
		int ys;
		bit valid;
		total = int'(cell_total_reg);
		sel = int'($urandom_range(9));
		if (sel < 7 && total != 0) begin
			c = int'($urandom_range(total > 65536 ? 65535 : total - 1));
		end else if (sel < 8) begin
			c = -1;
		end else if (sel < 9) begin
			c = total > 65535 ? 65535 : total;
		end else begin
			c = int'($urandom_range(65535));
		end
		valid = c >= 0 && c < total && cell_cols_reg != '0;
		xs = valid ? int'(cell_w_reg) : used_dim(sheet_w_reg, MAX_WIDTH);
		ys = valid ? int'(cell_h_reg) : used_dim(sheet_h_reg, MAX_HEIGHT);
		send_item(OP_QUERY, $urandom, COORD_W'(c), pick_coord(xs == 0 ? 1 : xs),
			pick_coord(ys == 0 ? 1 : ys), 1'b0, 1'b0);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (hits_pending.size() == 0) begin
				report($sformatf("hit=%b with no query outstanding", hit));
			end else begin
				if (hit !== hits_pending[0]) begin
					report($sformatf("hit=%b, expected %b", hit, hits_pending[0]));
				end
				void'(hits_pending.pop_front());
				hits_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d hits outstanding", cycles,
				hits_pending.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int phase;
		int span;
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(plan); i++) begin
			if (i == RESHAPE_ROW) begin
				settle();
				set_sheet(1'b1, 4, 2, 2, 1, 2, 4);
			end
			send_item(plan[i].op, plan[i].word, plan[i].cell_id, plan[i].x, plan[i].y,
				plan[i].fixed, plan[i].want);
		end

		for (phase = 0; beats_in < ITEM_TARGET; phase++) begin
			settle();
			case (phase)
				1: set_sheet(1'b1, 256, 1, 256, 256, 256, 65536);
				4: set_sheet(1'b1, 0, 256, 0, 0, 0, 0);
				7: set_sheet(1'b1, 300, 0, 1, 1, 3, 65535);
				default: set_sheet(1'b1, $urandom_range(1, 16), $urandom_range(1, 12),
					$urandom_range(6), $urandom_range(6), $urandom_range(4),
					$urandom_range(7) == 0 ? 65536 : $urandom_range(12));
			endcase

			span = used_dim(sheet_w_reg, MAX_WIDTH) * used_dim(sheet_h_reg, MAX_HEIGHT);
			if ($urandom_range(4) == 0) begin
				span = span / 2;    // only the first half of the sheet's pixels loaded
			end
			for (int k = 0; k < span; k++) begin
				if ($urandom_range(9) == 0) begin
					random_query();
				end
				send_item(OP_LOAD, $urandom, COORD_W'($urandom), COORD_W'($urandom),
					COORD_W'($urandom), 1'b0, 1'b0);
			end

			n = int'($urandom_range(30, 60));
			for (int k = 0; k < n; k++) begin
				if (k == n / 2) begin
					settle();
					set_sheet(1'b0, 0, 0, $urandom_range(8), $urandom_range(8),
						$urandom_range(5), $urandom_range(16));
				end
				if ($urandom_range(99) < 15) begin
					send_item(OP_LOAD, $urandom, COORD_W'($urandom), COORD_W'($urandom),
						COORD_W'($urandom), 1'b0, 1'b0);
				end else begin
					random_query();
				end
			end
		end

		settle();
		$display("%0d beats sent: %0d pixel loads, %0d hit queries, %0d register setups",
			beats_in, loads_in, queries_in, sheets);
		$display("%0d hit results checked, %0d mismatches", hits_checked, mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
